>>> design/hsn_pkg.sv
// shared constants, types and helpers of the heightmap smooth normals unit
`timescale 1ns / 1ps
`default_nettype none
package hsn_pkg;

  localparam int MaxColumns  = 1024;
  localparam int ColW        = $clog2(MaxColumns);
  localparam int GridColsW   = 11;
  localparam int RowW        = 16;
  localparam int SampleW     = 8;
  localparam int StepW       = 16;
  localparam int NormW       = 48;
  localparam int DiffW       = 12;
  localparam int MagW        = DiffW - 1;
  localparam int AreaW       = 2 * StepW;
  localparam int ProdW       = 44;
  localparam int NibbleCount = ProdW / 4;
  localparam int DivCntW     = $clog2(NibbleCount);
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgGridColumns = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGridRows    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGridStep    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgHeightStep  = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic load;
    logic setup;
    logic mul;
    logic div_step;
    logic pop;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic new_any;
    logic more;
  } ctrl_status_t;

  // one radix-16 quotient digit of a division by three, for t below 48
  function automatic logic [3:0] div3_digit(input logic [5:0] t);
    logic [12:0] m;
    m = 13'(t) * 13'd43;
    return m[10:7];
  endfunction

endpackage
`default_nettype wire

>>> design/hsn_sample_if.sv
// sample stream channel
`timescale 1ns / 1ps
`default_nettype none
interface hsn_sample_if;
  logic                        valid;
  logic                        ready;
  logic [hsn_pkg::SampleW-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

>>> design/hsn_normal_if.sv
// normal result channel
`timescale 1ns / 1ps
`default_nettype none
interface hsn_normal_if;
  logic                              valid;
  logic                              ready;
  logic [hsn_pkg::ColW-1:0]          vertex_col;
  logic [hsn_pkg::RowW-1:0]          vertex_row;
  logic signed [hsn_pkg::NormW-1:0]  normal_x;
  logic signed [hsn_pkg::NormW-1:0]  normal_y;
  logic signed [hsn_pkg::NormW-1:0]  normal_z;
  logic                              last_of_run;
  modport source (output valid, output vertex_col, output vertex_row, output normal_x,
                  output normal_y, output normal_z, output last_of_run, input ready);
  modport sink (input valid, input vertex_col, input vertex_row, input normal_x,
                input normal_y, input normal_z, input last_of_run, output ready);
endinterface
`default_nettype wire

>>> design/hsn_ctrl.sv
// controller state machine of the heightmap smooth normals unit
`timescale 1ns / 1ps
`default_nettype none
module hsn_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire hsn_pkg::ctrl_status_t status_i,
  output hsn_pkg::ctrl_cmd_t         cmd_o
);
  import hsn_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLoad  = 3'd1;
  localparam logic [2:0] StSetup = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;

  // handshake and commands
  always_comb begin
    in_ready_o   = (state_q == StIdle);
    out_valid_o  = (state_q == StOut);
    cmd_o          = '0;
    cmd_o.capture  = (state_q == StIdle) && in_valid_i;
    cmd_o.load     = (state_q == StLoad);
    cmd_o.setup    = (state_q == StSetup);
    cmd_o.mul      = (state_q == StMul);
    cmd_o.div_step = (state_q == StDiv);
    cmd_o.pop      = (state_q == StOut) && out_ready_i;
  end

  // next state
  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StLoad;
      end
      StLoad: begin
        state_d = status_i.new_any ? StSetup : StIdle;
      end
      StSetup: begin
        state_d = StMul;
      end
      StMul: begin
        state_d   = StDiv;
        div_cnt_d = '0;
      end
      StDiv: begin
        div_cnt_d = div_cnt_q + DivCntW'(1);
        if (div_cnt_q == DivCntW'(NibbleCount - 1)) state_d = StOut;
      end
      StOut: begin
        if (out_ready_i) state_d = status_i.more ? StSetup : StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> design/hsn_datapath.sv
// datapath: configuration, counters, row store, window, cross sums and division
`timescale 1ns / 1ps
`default_nettype none
module hsn_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [hsn_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [hsn_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic [hsn_pkg::SampleW-1:0]  sample_i,
  input  wire hsn_pkg::ctrl_cmd_t           cmd_i,
  output hsn_pkg::ctrl_status_t             status_o,
  output logic [hsn_pkg::ColW-1:0]          vertex_col_o,
  output logic [hsn_pkg::RowW-1:0]          vertex_row_o,
  output logic signed [hsn_pkg::NormW-1:0]  normal_x_o,
  output logic signed [hsn_pkg::NormW-1:0]  normal_y_o,
  output logic signed [hsn_pkg::NormW-1:0]  normal_z_o,
  output logic                              last_of_run_o
);
  import hsn_pkg::*;

  // configuration registers
  logic [GridColsW-1:0] grid_cols_q;
  logic [RowW-1:0]      grid_rows_q;
  logic [StepW-1:0]     grid_step_q, height_step_q;

  // frame position
  logic [ColW-1:0] col_q, c_q;
  logic [RowW-1:0] row_q, r_q;

  // row store: one entry per column, {row r-1, row r-2}
  logic [2*SampleW-1:0] mem_q [MaxColumns];
  logic [2*SampleW-1:0] rd_q;
  logic [SampleW-1:0]   sample_q;

  // 3x3 window: [row top..bottom][column oldest..newest]
  logic [SampleW-1:0] win_q [3][3];

  logic [3:0] pend_q, sel;
  logic       more;

  logic [GridColsW-1:0] w_eff;
  logic [ColW-1:0]      w_last;
  logic [RowW-1:0]      h_last;

  // effective dimensions
  always_comb begin
    if (grid_cols_q < GridColsW'(2)) w_eff = GridColsW'(2);
    else if (grid_cols_q > GridColsW'(MaxColumns)) w_eff = GridColsW'(MaxColumns);
    else w_eff = grid_cols_q;
    w_last = ColW'(w_eff - GridColsW'(1));
    h_last = (grid_rows_q < RowW'(2)) ? RowW'(1) : grid_rows_q - RowW'(1);
  end

  // configuration writes and frame counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q   <= GridColsW'(256);
      grid_rows_q   <= RowW'(256);
      grid_step_q   <= StepW'(256);
      height_step_q <= StepW'(256);
      col_q         <= '0;
      row_q         <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgGridColumns: begin
          grid_cols_q <= cfg_wdata_i[GridColsW-1:0];
          col_q       <= '0;
          row_q       <= '0;
        end
        CfgGridRows: begin
          grid_rows_q <= cfg_wdata_i[RowW-1:0];
          col_q       <= '0;
          row_q       <= '0;
        end
        CfgGridStep:   grid_step_q   <= cfg_wdata_i[StepW-1:0];
        CfgHeightStep: height_step_q <= cfg_wdata_i[StepW-1:0];
        default: ;
      endcase
    end else if (cmd_i.capture) begin
      if (col_q == w_last) begin
        col_q <= '0;
        row_q <= (row_q == h_last) ? '0 : row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // sample capture and row store access
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= sample_i;
      rd_q     <= mem_q[col_q];
      r_q      <= row_q;
      c_q      <= col_q;
    end
    if (cmd_i.load) begin
      mem_q[c_q] <= {sample_q, rd_q[2*SampleW-1:SampleW]};
    end
  end

  // emission flags of the current sample
  logic e0, e2, last_c;
  always_comb begin
    last_c = (c_q == w_last);
    e0     = (r_q != '0) && (c_q != '0);
    e2     = (r_q == h_last) && (c_q != '0);
    status_o.new_any = e0 || e2;
    sel  = pend_q & (~pend_q + 4'd1);
    more = (pend_q & ~sel) != 4'd0;
    status_o.more = more;
  end

  // window shift and pending results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
      end
    end else if (cmd_i.load) begin
      pend_q <= {e2 && last_c, e2, e0 && last_c, e0};
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= rd_q[SampleW-1:0];
      win_q[1][2] <= rd_q[2*SampleW-1:SampleW];
      win_q[2][2] <= sample_q;
    end else if (cmd_i.pop) begin
      pend_q <= pend_q & ~sel;
    end
  end

  // neighborhood of the selected vertex and its difference sums
  logic [SampleW-1:0]      nb [3][3];
  logic [5:0]              use_t;
  logic signed [DiffW-1:0] tx [6];
  logic signed [DiffW-1:0] tz [6];
  logic signed [DiffW-1:0] dx, dz;
  logic [ColW-1:0]         vc;
  logic [RowW-1:0]         vr;
  logic [2:0]              cnt;

  function automatic logic signed [DiffW-1:0] ext(input logic [SampleW-1:0] v);
    return $signed({{(DiffW-SampleW){1'b0}}, v});
  endfunction

  always_comb begin
    logic [1:0] rc, cc;
    logic [2:0] ri, ci;
    rc = (sel[2] || sel[3]) ? 2'd2 : 2'd1;
    cc = (sel[1] || sel[3]) ? 2'd2 : 2'd1;
    vr = (sel[0] || sel[1]) ? r_q - RowW'(1) : r_q;
    vc = (sel[0] || sel[2]) ? c_q - ColW'(1) : c_q;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ri = {1'b0, rc} + 3'(i) - 3'd1;
        ci = {1'b0, cc} + 3'(j) - 3'd1;
        nb[i][j] = (ri <= 3'd2 && ci <= 3'd2) ? win_q[ri[1:0]][ci[1:0]] : '0;
      end
    end
    use_t[0] = (vc != '0) && (vr != '0);
    use_t[1] = use_t[0];
    use_t[2] = (vc != w_last) && (vr != h_last);
    use_t[3] = use_t[2];
    use_t[4] = (vc != '0) && (vr != h_last);
    use_t[5] = (vc != w_last) && (vr != '0);
    // per-triangle height differences of the x and z cross components
    tx[0] = ext(nb[1][0]) - ext(nb[1][1]);  tz[0] = ext(nb[0][0]) - ext(nb[1][0]);
    tx[1] = ext(nb[0][0]) - ext(nb[0][1]);  tz[1] = ext(nb[0][1]) - ext(nb[1][1]);
    tx[2] = ext(nb[2][1]) - ext(nb[2][2]);  tz[2] = ext(nb[1][1]) - ext(nb[2][1]);
    tx[3] = ext(nb[1][1]) - ext(nb[1][2]);  tz[3] = ext(nb[1][2]) - ext(nb[2][2]);
    tx[4] = ext(nb[1][0]) - ext(nb[1][1]);  tz[4] = ext(nb[1][1]) - ext(nb[2][1]);
    tx[5] = ext(nb[1][1]) - ext(nb[1][2]);  tz[5] = ext(nb[0][1]) - ext(nb[1][1]);
    dx = '0;
    dz = '0;
    for (int t = 0; t < 6; t++) begin
      if (use_t[t]) begin
        dx = dx + tx[t];
        dz = dz + tz[t];
      end
    end
    cnt = 3'($countones(use_t));
  end

  // setup stage registers
  logic signed [DiffW-1:0] dx_q, dz_q;
  logic [AreaW-1:0]        area_q, ysq_q;
  logic                    half_q, third_q, last_q;
  logic [ColW-1:0]         vc_q;
  logic [RowW-1:0]         vr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      dx_q    <= dx;
      dz_q    <= dz;
      area_q  <= AreaW'(grid_step_q) * AreaW'(height_step_q);
      ysq_q   <= AreaW'(grid_step_q) * AreaW'(grid_step_q);
      half_q  <= (cnt == 3'd2) || (cnt == 3'd6);
      third_q <= (cnt == 3'd3) || (cnt == 3'd6);
      last_q  <= !more;
      vc_q    <= vc;
      vr_q    <= vr;
    end
  end

  // product of area and difference magnitude, halved for even counts
  logic [MagW-1:0]  magx, magz;
  logic [ProdW-1:0] prodx, prodz;
  always_comb begin
    logic signed [DiffW-1:0] ax, az;
    ax    = dx_q[DiffW-1] ? -dx_q : dx_q;
    az    = dz_q[DiffW-1] ? -dz_q : dz_q;
    magx  = ax[MagW-1:0];
    magz  = az[MagW-1:0];
    prodx = ProdW'(area_q) * ProdW'(magx);
    prodz = ProdW'(area_q) * ProdW'(magz);
    if (half_q) begin
      prodx = prodx >> 1;
      prodz = prodz >> 1;
    end
  end

  // radix-16 divide by three, one nibble per cycle on both lanes
  logic [ProdW-1:0] px_q, pz_q, dvx_q, dvz_q, qx_q, qz_q;
  logic [1:0]       remx_q, remz_q;
  logic [5:0]       tx_d, tz_d;
  logic [3:0]       qdx, qdz;
  logic [5:0]       rx_d, rz_d;

  always_comb begin
    tx_d = {remx_q, dvx_q[ProdW-1 -: 4]};
    tz_d = {remz_q, dvz_q[ProdW-1 -: 4]};
    qdx  = div3_digit(tx_d);
    qdz  = div3_digit(tz_d);
    rx_d = tx_d - 6'(qdx) * 6'd3;
    rz_d = tz_d - 6'(qdz) * 6'd3;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      px_q   <= prodx;
      pz_q   <= prodz;
      dvx_q  <= prodx;
      dvz_q  <= prodz;
      remx_q <= '0;
      remz_q <= '0;
      qx_q   <= '0;
      qz_q   <= '0;
    end else if (cmd_i.div_step) begin
      dvx_q  <= dvx_q << 4;
      dvz_q  <= dvz_q << 4;
      remx_q <= rx_d[1:0];
      remz_q <= rz_d[1:0];
      qx_q   <= {qx_q[ProdW-5:0], qdx};
      qz_q   <= {qz_q[ProdW-5:0], qdz};
    end
  end

  // result payload with sign restored
  always_comb begin
    logic [NormW-1:0] mx, mz;
    mx = NormW'(third_q ? qx_q : px_q);
    mz = NormW'(third_q ? qz_q : pz_q);
    normal_x_o    = dx_q[DiffW-1] ? -$signed(mx) : $signed(mx);
    normal_z_o    = dz_q[DiffW-1] ? -$signed(mz) : $signed(mz);
    normal_y_o    = $signed(NormW'(ysq_q));
    vertex_col_o  = vc_q;
    vertex_row_o  = vr_q;
    last_of_run_o = last_q;
  end

endmodule
`default_nettype wire

>>> design/heightmap_smooth_normals_unit.sv
// top level of the heightmap smooth normals unit
//
// channel    dir  payload                                            transfer when
// sample_if  in   sample                                             valid & ready
// normal_if  out  vertex_col vertex_row normal_x/y/z last_of_run     valid & ready
// cfg        in   cfg_index_i cfg_wdata_i                            cfg_we_i
//
// one sample at a time: the store read and window update, then for each normal
// setup, multiply, 11 divide-by-three steps and output, for a sample that causes
// n normals (n up to 4).
// the divide-by-three unit, one nibble per cycle, sets the per-normal time.
// reset zeroes counters and window, sets config to 256; the row store needs no clearing.
// a stalled output holds the block; no new sample is taken until all normals leave.
`timescale 1ns / 1ps
`default_nettype none
module heightmap_smooth_normals_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  hsn_sample_if.sink                        sample_if,
  hsn_normal_if.source                      normal_if,
  input  wire logic                         cfg_we_i,
  input  wire logic [hsn_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [hsn_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import hsn_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // sequencing
  hsn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_if.valid),
    .in_ready_o  (sample_if.ready),
    .out_valid_o (normal_if.valid),
    .out_ready_i (normal_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and storage
  hsn_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .sample_i      (sample_if.sample),
    .cmd_i         (cmd),
    .status_o      (status),
    .vertex_col_o  (normal_if.vertex_col),
    .vertex_row_o  (normal_if.vertex_row),
    .normal_x_o    (normal_if.normal_x),
    .normal_y_o    (normal_if.normal_y),
    .normal_z_o    (normal_if.normal_z),
    .last_of_run_o (normal_if.last_of_run)
  );

  // no sample is taken while a normal is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    normal_if.valid |-> !sample_if.ready)
    else $error("sample taken while a normal is pending");

  // a sample transfer closes the input until its work is done
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_if.valid && sample_if.ready) |=> !sample_if.ready)
    else $error("input reopened right after a transfer");

  // the last normal of a run hands back to the input
  a_last_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (normal_if.valid && normal_if.ready && normal_if.last_of_run) |=> sample_if.ready)
    else $error("input not reopened after the last normal");

  // a normal that is not the last one is followed by another
  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (normal_if.valid && normal_if.ready && !normal_if.last_of_run) |=> !sample_if.ready)
    else $error("run ended early");

endmodule
`default_nettype wire
